[rtl/fltp_pkg.sv]
// fltp_pkg: shared types and constants for the flow tag free list pool
// opcodes, status codes, beat layouts and the controller/datapath handshake structs
// no dependencies
package fltp_pkg;

  // opcode carried in the low bits of an input beat
  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_INIT  = 2'd3
  } func_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  // field widths fixed by the beat format
  localparam int FUNC_W     = 2;
  localparam int TAG_IN_W   = 16;
  localparam int FLOW_W     = 64;
  localparam int STATUS_W   = 2;
  localparam int TAG_OUT_W  = 10;
  localparam int POOL_W     = 11;
  localparam int S_DATA_W   = 88;
  localparam int M_DATA_W   = 80;
  localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;

  // input beat bit positions
  localparam int S_FUNC_LSB = 0;
  localparam int S_TAG_LSB  = S_FUNC_LSB + FUNC_W;
  localparam int S_FLOW_LSB = S_TAG_LSB + TAG_IN_W;

  // output beat bit positions
  localparam int M_STATUS_LSB = 0;
  localparam int M_TAG_LSB    = M_STATUS_LSB + STATUS_W;
  localparam int M_FLOW_LSB   = M_TAG_LSB + TAG_OUT_W;
  localparam int M_VALID_LSB  = M_FLOW_LSB + FLOW_W;

  // controller to datapath
  typedef struct packed {
    logic capture;      // take an input beat, launch memory reads
    logic commit;       // finish the op, load the output register
    logic link_fix;     // second link write of a free
    logic sweep_start;  // latch pool size, reset sweep counter
    logic sweep_step;   // relink one entry
  } fltp_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t in_func;     // opcode of the beat on the input
    logic  need_link;   // captured op is a free within range
    logic  sweep_last;  // sweep counter at the last pool entry
    logic  out_busy;    // output register holds a beat not taken this cycle
  } fltp_sts_t;

endpackage

[rtl/fltp_ctrl.sv]
// fltp_ctrl: sequencing state machine of the tag pool
// depends on fltp_pkg; drives commands into fltp_datapath
module fltp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  fltp_pkg::fltp_sts_t sts,
  output fltp_pkg::fltp_cmd_t cmd
);
  import fltp_pkg::*;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC,
    ST_LINK,
    ST_REPORT
  } state_t;

  state_t state;
  logic   report;   // sweep came from a reinitialise beat, so a result is owed

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tready && s_tvalid;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.capture     = accept;
        cmd.sweep_start = accept && (sts.in_func == FUNC_INIT);
      end
      ST_EXEC:   cmd.commit     = !sts.out_busy;
      ST_LINK:   cmd.link_fix   = 1'b1;
      ST_SWEEP:  cmd.sweep_step = 1'b1;
      ST_REPORT: cmd.commit     = !sts.out_busy;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_SWEEP;
      report <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (sts.in_func == FUNC_INIT) begin
              state  <= ST_SWEEP;
              report <= 1'b1;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          if (!sts.out_busy) begin
            state <= sts.need_link ? ST_LINK : ST_IDLE;
          end
        end
        ST_LINK: state <= ST_IDLE;
        ST_SWEEP: begin
          if (sts.sweep_last) begin
            state <= report ? ST_REPORT : ST_IDLE;
          end
        end
        ST_REPORT: begin
          if (!sts.out_busy) begin
            state  <= ST_IDLE;
            report <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/fltp_datapath.sv]
// fltp_datapath: link memory, flow memory, head/tail pointers, sweep counter, output register
// depends on fltp_pkg; commanded by fltp_ctrl
module fltp_datapath #(
  parameter int TAGS      = 1024,
  parameter int FLOW_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [fltp_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                           m_tready,
  output logic                           m_tvalid,
  output logic [fltp_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                           cfg_we,
  input  logic [fltp_pkg::POOL_W-1:0]    cfg_data,
  input  fltp_pkg::fltp_cmd_t            cmd,
  output fltp_pkg::fltp_sts_t            sts
);
  import fltp_pkg::*;

  localparam int TW      = (TAGS > 1) ? $clog2(TAGS) : 1;
  localparam int PW      = TW + 1;                       // pointer width, null is TAGS
  localparam int RESET_N = (1024 > TAGS) ? TAGS : 1024;
  localparam logic [PW-1:0] NULL_PTR = PW'(TAGS);

  logic [PW-1:0]        link_mem [TAGS];
  logic [FLOW_BITS-1:0] flow_mem [TAGS];

  logic [POOL_W-1:0]    pool_cfg;
  logic [PW-1:0]        pool_n;
  logic [PW-1:0]        sweep_n;
  logic [PW-1:0]        cnt;
  logic [PW-1:0]        head;
  logic [PW-1:0]        tail;

  func_t                op_func;
  logic [TW-1:0]        op_tag;
  logic                 op_oor;
  logic [FLOW_BITS-1:0] op_flow;
  logic [PW-1:0]        link_rd;
  logic [FLOW_BITS-1:0] flow_rd;

  func_t                in_func;
  logic [TAG_IN_W-1:0]  in_tag;
  logic                 in_oor;
  logic                 head_null;
  logic                 tail_null;
  logic                 sweep_last;

  logic                 link_we;
  logic [TW-1:0]        link_wa;
  logic [PW-1:0]        link_wd;
  logic                 flow_we;

  logic [STATUS_W-1:0]  res_status;
  logic [TW-1:0]        res_tag;
  logic [FLOW_BITS-1:0] res_flow;
  logic                 res_ev;

  assign in_func    = func_t'(s_tdata[S_FUNC_LSB +: FUNC_W]);
  assign in_tag     = s_tdata[S_TAG_LSB +: TAG_IN_W];
  assign in_oor     = {1'b0, in_tag} >= 17'(TAGS);
  assign head_null  = head >= NULL_PTR;
  assign tail_null  = tail >= NULL_PTR;
  assign sweep_last = cnt == (sweep_n - PW'(1));

  assign sts.in_func    = in_func;
  assign sts.need_link  = (op_func == FUNC_FREE) && !op_oor;
  assign sts.sweep_last = sweep_last;
  assign sts.out_busy   = m_tvalid && !m_tready;

  // pool size clipped to 1..TAGS
  always_comb begin
    if (pool_cfg == '0) begin
      pool_n = PW'(1);
    end else if (32'(pool_cfg) > TAGS) begin
      pool_n = PW'(TAGS);
    end else begin
      pool_n = PW'(pool_cfg);
    end
  end

  // single link write port: sweep, append at tail, terminate freed entry
  always_comb begin
    link_we = 1'b0;
    link_wa = '0;
    link_wd = '0;
    if (cmd.sweep_step) begin
      link_we = 1'b1;
      link_wa = cnt[TW-1:0];
      link_wd = sweep_last ? NULL_PTR : cnt + PW'(1);
    end else if (cmd.commit && sts.need_link && !tail_null) begin
      link_we = 1'b1;
      link_wa = tail[TW-1:0];
      link_wd = {1'b0, op_tag};
    end else if (cmd.link_fix) begin
      link_we = 1'b1;
      link_wa = op_tag;
      link_wd = NULL_PTR;
    end
  end

  assign flow_we = cmd.commit && (op_func == FUNC_ALLOC) && !head_null;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd.capture) begin
      link_rd <= link_mem[head[TW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (flow_we) begin
      flow_mem[head[TW-1:0]] <= op_flow;
    end
    if (cmd.capture) begin
      flow_rd <= flow_mem[in_tag[TW-1:0]];
    end
  end

  // captured operands
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func <= in_func;
      op_tag  <= in_tag[TW-1:0];
      op_oor  <= in_oor;
      op_flow <= s_tdata[S_FLOW_LSB +: FLOW_BITS];
    end
  end

  // result of the captured op; entry_valid is set by a successful allocate or an in-range read
  always_comb begin
    res_status = STATUS_OK;
    res_tag    = '0;
    res_flow   = '0;
    res_ev     = 1'b0;
    case (op_func)
      FUNC_ALLOC: begin
        if (head_null) begin
          res_status = STATUS_NO_FREE;
        end else begin
          res_tag = head[TW-1:0];
          res_ev  = 1'b1;
        end
      end
      FUNC_FREE: begin
        if (op_oor) begin
          res_status = STATUS_RANGE;
        end else begin
          res_tag = op_tag;
        end
      end
      FUNC_READ: begin
        if (op_oor) begin
          res_status = STATUS_RANGE;
        end else begin
          res_tag  = op_tag;
          res_flow = flow_rd;
          res_ev   = 1'b1;
        end
      end
      default: res_status = STATUS_OK;
    endcase
  end

  // pointers, sweep counter, config register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_cfg  <= POOL_RESET;
      sweep_n   <= PW'(RESET_N);
      cnt       <= '0;
      head      <= '0;
      tail      <= PW'(RESET_N - 1);
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_cfg <= cfg_data;
      end

      if (cmd.sweep_start) begin
        sweep_n <= pool_n;
        cnt     <= '0;
      end else if (cmd.sweep_step) begin
        cnt <= cnt + PW'(1);
        if (sweep_last) begin
          head <= '0;
          tail <= sweep_n - PW'(1);
        end
      end

      if (cmd.commit) begin
        if (op_func == FUNC_ALLOC && !head_null) begin
          head <= link_rd;
          if (link_rd >= NULL_PTR) begin
            tail <= NULL_PTR;
          end
        end else if (sts.need_link) begin
          if (tail_null) begin
            head <= {1'b0, op_tag};
          end
          tail <= {1'b0, op_tag};
        end
      end

      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {{(M_DATA_W - M_VALID_LSB - 1){1'b0}}, res_ev, FLOW_W'(res_flow),
                  TAG_OUT_W'(res_tag), res_status};
    end
  end

endmodule

[rtl/flow_tag_free_list_pool.sv]
// flow_tag_free_list_pool: tag allocator kept as a linked free list with head and tail
// depends on fltp_pkg, fltp_ctrl and fltp_datapath
//
// input beats on s_t*: allocate, free, read a stored flow word, or reinitialise the pool.
// every input beat gives exactly one output beat on m_t* with a status, the tag,
// the flow word (reads only) and entry_valid (successful allocate or in-range read).
// cfg_we/cfg_data write the pool size; it takes effect at the next reinitialise.
// one item at a time: every beat except reinitialise passes through ST_EXEC, which
// loads the output register once it is free; a free in range then passes ST_LINK too
// (two writes through the single link memory port) before the next beat is accepted.
// reinitialise relinks one entry per cycle in ST_SWEEP, then reports in ST_REPORT.
// after reset s_tready stays low while the first min(1024, TAGS) link memory entries
// are relinked; flow words are not cleared and only defined once allocated.
// the output register holds a result while m_tready is low; one further beat may be
// accepted and worked up to its result, which then waits for the register to empty.
module flow_tag_free_list_pool #(
  parameter int TAGS      = 1024,
  parameter int FLOW_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // func[1:0], tag_in[17:2], flow_in[81:18], zero pad
  input  logic [fltp_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[1:0], tag_out[11:2], flow_out[75:12], entry_valid[76], zero pad
  output logic [fltp_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                          cfg_we,
  input  logic [fltp_pkg::POOL_W-1:0]   cfg_data
);
  import fltp_pkg::*;

  fltp_cmd_t cmd;
  fltp_sts_t sts;

  fltp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fltp_datapath #(
    .TAGS      (TAGS),
    .FLOW_BITS (FLOW_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

[test/tb_flow_tag_free_list_pool.sv]
`timescale 1ns / 100ps
// tb_flow_tag_free_list_pool: self-checking bench for the flow tag free list pool
// a directed table then phased random traffic, checked against typed table results or a free list predictor
// depends on fltp_pkg and flow_tag_free_list_pool
module tb_flow_tag_free_list_pool;
  import fltp_pkg::*;

  localparam int TAGS = 1024;
  localparam logic [POOL_W-1:0] NULL_TAG = 11'd1024;
  localparam int RAND_ITEMS = 1350;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam logic [FLOW_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [TAG_OUT_W-1:0] tag;
    logic [FLOW_W-1:0]    flow;
    logic                 valid;
  } pool_result_t;

  // one row of the directed table: either a pool size write or an input beat
  typedef struct packed {
    bit                  cfg;
    logic [POOL_W-1:0]   pool;
    func_t               func;
    logic [TAG_IN_W-1:0] tag;
    logic [FLOW_W-1:0]   flow;
    bit                  typed;
    pool_result_t        res;
  } step_row_t;

  localparam pool_result_t RANGE_RES = '{STATUS_RANGE, 10'd0, 64'd0, 1'b0};
  localparam pool_result_t INIT_RES  = '{STATUS_OK, 10'd0, 64'd0, 1'b0};
  localparam pool_result_t NO_RES    = '0;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_we;
  logic [POOL_W-1:0]     cfg_data;

  // predictor state
  logic [POOL_W-1:0]  link_tab [TAGS];
  logic [FLOW_W-1:0]  flow_tab [TAGS];
  bit                 mark_tab [TAGS];
  logic [POOL_W-1:0]  head_tag;
  logic [POOL_W-1:0]  tail_tag;
  logic [POOL_W-1:0]  pool_reg;

  pool_result_t       expected_q [$];
  logic [TAG_OUT_W-1:0] held_tags [$];
  logic [TAG_OUT_W-1:0] known_tags [$];
  bit                 known_map [TAGS];
  int                 fail_cnt = 0;
  int                 tx_idle_pct = 33;
  int                 rx_idle_pct = 72;
  bit                 hold_req = 1'b0;
  int                 stall_cycles = 0;

  step_row_t dir_tab [26] = '{
    '{0, 11'd0,    FUNC_READ,  16'd1024,  64'd0, 1, RANGE_RES},
    '{0, 11'd0,    FUNC_READ,  16'hffff,  64'd0, 1, RANGE_RES},
    '{0, 11'd0,    FUNC_FREE,  16'hffff,  64'd0, 1, RANGE_RES},
    '{0, 11'd0,    FUNC_FREE,  16'h8000,  64'd0, 1, RANGE_RES},
    '{0, 11'd0,    FUNC_ALLOC, 16'hffff,  64'd0, 1, '{STATUS_OK, 10'd0, 64'd0, 1'b1}},
    '{0, 11'd0,    FUNC_ALLOC, 16'd0,  ALL_ONES, 1, '{STATUS_OK, 10'd1, 64'd0, 1'b1}},
    '{0, 11'd0,    FUNC_READ,  16'd1,     64'd0, 1, '{STATUS_OK, 10'd1, ALL_ONES, 1'b1}},
    '{0, 11'd0,    FUNC_READ,  16'd0,     64'd0, 1, '{STATUS_OK, 10'd0, 64'd0, 1'b1}},
    '{0, 11'd0,    FUNC_FREE,  16'd1,     64'd0, 1, '{STATUS_OK, 10'd1, 64'd0, 1'b0}},
    // second free of the same tag is linked again
    '{0, 11'd0,    FUNC_FREE,  16'd1,     64'd0, 1, '{STATUS_OK, 10'd1, 64'd0, 1'b0}},
    '{0, 11'd0,    FUNC_READ,  16'd1,     64'd0, 1, '{STATUS_OK, 10'd1, ALL_ONES, 1'b1}},
    '{0, 11'd0,    FUNC_INIT,  16'd0,     64'd0, 1, INIT_RES},
    // size zero acts as one
    '{1, 11'd0,    FUNC_ALLOC, 16'd0,     64'd0, 0, NO_RES},
    '{0, 11'd0,    FUNC_INIT,  16'd0,     64'd0, 1, INIT_RES},
    '{0, 11'd0,    FUNC_ALLOC, 16'd0, 64'h0123_4567_89ab_cdef, 1,
      '{STATUS_OK, 10'd0, 64'd0, 1'b1}},
    '{0, 11'd0,    FUNC_ALLOC, 16'd0, 64'h5555_aaaa_5555_aaaa, 1,
      '{STATUS_NO_FREE, 10'd0, 64'd0, 1'b0}},
    // tag above the pool but inside the table
    '{0, 11'd0,    FUNC_FREE,  16'd1023,  64'd0, 1, '{STATUS_OK, 10'd1023, 64'd0, 1'b0}},
    '{0, 11'd0,    FUNC_ALLOC, 16'd0, 64'hfedc_ba98_7654_3210, 1,
      '{STATUS_OK, 10'd1023, 64'd0, 1'b1}},
    '{0, 11'd0,    FUNC_READ,  16'd1023,  64'd0, 0, NO_RES},
    '{0, 11'd0,    FUNC_FREE,  16'd0,     64'd0, 0, NO_RES},
    // above the table, clipped
    '{1, 11'd2047, FUNC_ALLOC, 16'd0,     64'd0, 0, NO_RES},
    '{0, 11'd0,    FUNC_INIT,  16'd0,     64'd0, 1, INIT_RES},
    '{0, 11'd0,    FUNC_ALLOC, 16'd0, 64'h8000_0000_0000_0001, 1,
      '{STATUS_OK, 10'd0, 64'd0, 1'b1}},
    '{0, 11'd0,    FUNC_READ,  16'd0,     64'd0, 0, NO_RES},
    '{1, 11'd1,    FUNC_ALLOC, 16'd0,     64'd0, 0, NO_RES},
    '{0, 11'd0,    FUNC_INIT,  16'd0,     64'd0, 1, INIT_RES}
  };

  flow_tag_free_list_pool #(
    .TAGS      (TAGS),
    .FLOW_BITS (FLOW_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void pool_relink();
    int n;
    n = (pool_reg == 0) ? 1 : (pool_reg > TAGS) ? TAGS : int'(pool_reg);
    for (int i = 0; i < n; i++) link_tab[i] = POOL_W'(i + 1);
    link_tab[n-1] = NULL_TAG;
    foreach (mark_tab[i]) mark_tab[i] = 1'b0;
    head_tag = '0;
    tail_tag = POOL_W'(n - 1);
  endfunction

  function automatic pool_result_t pool_step(func_t op, logic [TAG_IN_W-1:0] tag_in,
                                             logic [FLOW_W-1:0] flow_in);
    pool_result_t r;
    logic [POOL_W-1:0] idx;
    logic [POOL_W-1:0] nxt;
    r = '0;
    r.status = STATUS_OK;
    case (op)
      FUNC_ALLOC: begin
        if (head_tag >= NULL_TAG) begin
          r.status = STATUS_NO_FREE;
        end else begin
          idx = head_tag;
          nxt = link_tab[idx];
          head_tag = nxt;
          if (nxt >= NULL_TAG) tail_tag = NULL_TAG;
          flow_tab[idx] = flow_in;
          mark_tab[idx] = 1'b1;
          r.tag = idx[TAG_OUT_W-1:0];
          r.valid = 1'b1;
        end
      end
      FUNC_FREE: begin
        if (tag_in >= TAGS) begin
          r.status = STATUS_RANGE;
        end else begin
          idx = tag_in[POOL_W-1:0];
          // empty list: the freed tag becomes the head
          if (tail_tag >= NULL_TAG) head_tag = idx;
          else link_tab[tail_tag] = idx;
          tail_tag = idx;
          link_tab[idx] = NULL_TAG;
          mark_tab[idx] = 1'b0;
          r.tag = idx[TAG_OUT_W-1:0];
        end
      end
      FUNC_READ: begin
        if (tag_in >= TAGS) begin
          r.status = STATUS_RANGE;
        end else begin
          idx = tag_in[POOL_W-1:0];
          mark_tab[idx] = 1'b1;
          r.flow = flow_tab[idx];
          r.tag = idx[TAG_OUT_W-1:0];
          r.valid = 1'b1;
        end
      end
      default: pool_relink();
    endcase
    return r;
  endfunction

  // offers one beat, predicts at the accepting edge and tracks which tags are live
  task automatic offer_beat(input func_t op, input logic [TAG_IN_W-1:0] tag_in,
                            input logic [FLOW_W-1:0] flow_in, input bit typed,
                            input pool_result_t typed_res);
    logic [S_DATA_W-1:0] beat;
    pool_result_t r;
    int hit;
    beat = '0;
    beat[S_FUNC_LSB +: FUNC_W] = op;
    beat[S_TAG_LSB +: TAG_IN_W] = tag_in;
    beat[S_FLOW_LSB +: FLOW_W] = flow_in;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = pool_step(op, tag_in, flow_in);
    expected_q.push_back(typed ? typed_res : r);
    if (op == FUNC_ALLOC && r.status == STATUS_OK) begin
      held_tags.push_back(r.tag);
      if (!known_map[r.tag]) begin
        known_map[r.tag] = 1'b1;
        known_tags.push_back(r.tag);
      end
    end else if (op == FUNC_FREE && r.status == STATUS_OK) begin
      hit = -1;
      foreach (held_tags[i]) if (hit < 0 && held_tags[i] == r.tag) hit = i;
      if (hit >= 0) held_tags.delete(hit);
    end else if (op == FUNC_INIT) begin
      held_tags.delete();
    end
  endtask

  // pool size is only written once every result is back
  task automatic set_pool_size(input logic [POOL_W-1:0] val);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_reg = val;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    pool_result_t want;
    pool_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[M_STATUS_LSB +: STATUS_W];
      got.tag    = m_tdata[M_TAG_LSB +: TAG_OUT_W];
      got.flow   = m_tdata[M_FLOW_LSB +: FLOW_W];
      got.valid  = m_tdata[M_VALID_LSB];
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: status %0d tag %0d", got.status, got.tag);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_cnt++;
        end
        if (got.tag !== want.tag) begin
          $error("tag_out: expected %0d, got %0d", want.tag, got.tag);
          fail_cnt++;
        end
        if (got.flow !== want.flow) begin
          $error("flow_out: expected %h, got %h", want.flow, got.flow);
          fail_cnt++;
        end
        if (got.valid !== want.valid) begin
          $error("entry_valid: expected %0d, got %0d", want.valid, got.valid);
          fail_cnt++;
        end
      end
    end
  end

  // covers a full-size relink and the long hold-off several times over
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("flow_tag_free_list_pool: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n_rand;
    int phase_len;
    int pick;
    logic [POOL_W-1:0]   pool_val;
    func_t               op;
    logic [TAG_IN_W-1:0] tg;
    logic [FLOW_W-1:0]   fw;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    foreach (known_map[i]) known_map[i] = 1'b0;
    foreach (flow_tab[i]) flow_tab[i] = '0;
    pool_reg = POOL_RESET;
    pool_relink();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg) set_pool_size(dir_tab[i].pool);
      else offer_beat(dir_tab[i].func, dir_tab[i].tag, dir_tab[i].flow,
                      dir_tab[i].typed, dir_tab[i].res);
    end

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      // mostly small pools so that the list runs dry; a full-size pool now and then
      pick = $urandom_range(9);
      if (pick == 0) pool_val = '0;
      else if (pick == 1) pool_val = 11'd1;
      else if (pick == 2) pool_val = POOL_W'($urandom_range(2047, 1024));
      else pool_val = POOL_W'($urandom_range(48, 2));
      set_pool_size(pool_val);
      offer_beat(FUNC_INIT, TAG_IN_W'($urandom), {$urandom, $urandom}, 1'b0, NO_RES);
      phase_len = $urandom_range(90, 30);
      for (int j = 0; j < phase_len && n_rand < RAND_ITEMS; j++) begin
        if (n_rand < 450) begin
          tx_idle_pct = 33;
          rx_idle_pct = 72;
        end else if (n_rand < 900) begin
          tx_idle_pct = 72;
          rx_idle_pct = 33;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        if (n_rand == 200 || n_rand == 1000) hold_req = 1'b1;

        op = FUNC_ALLOC;
        tg = TAG_IN_W'($urandom);
        fw = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick >= 40 && pick < 65 && held_tags.size() != 0) begin
          op = FUNC_FREE;
          tg = TAG_IN_W'(held_tags[$urandom_range(held_tags.size() - 1)]);
        end else if (pick >= 65 && pick < 85 && known_tags.size() != 0) begin
          op = FUNC_READ;
          tg = TAG_IN_W'(known_tags[$urandom_range(known_tags.size() - 1)]);
        end else if (pick >= 85) begin
          // noise: stray frees, out of range indexes, the odd reinitialise
          case ($urandom_range(9))
            0, 1, 2, 3: begin
              op = FUNC_FREE;
              tg = TAG_IN_W'($urandom_range(TAGS - 1));
            end
            4, 5: begin
              op = FUNC_FREE;
              tg = TAG_IN_W'($urandom_range(65535, TAGS));
            end
            6, 7: begin
              op = FUNC_READ;
              tg = TAG_IN_W'($urandom_range(65535, TAGS));
            end
            8: begin
              if (known_tags.size() != 0) begin
                op = FUNC_READ;
                tg = TAG_IN_W'(known_tags[$urandom_range(known_tags.size() - 1)]);
              end
            end
            default: if ($urandom_range(2) == 0) op = FUNC_INIT;
          endcase
        end
        offer_beat(op, tg, fw, 1'b0, NO_RES);
        n_rand++;
      end
    end

    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("flow_tag_free_list_pool: match");
    end else begin
      $display("flow_tag_free_list_pool: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/fltp_pkg.sv
rtl/fltp_ctrl.sv
rtl/fltp_datapath.sv
rtl/flow_tag_free_list_pool.sv
test/tb_flow_tag_free_list_pool.sv
